>>> rtl/core/v17_receiver_training_sequencer_top_defines.svh
// Assertion macros for the V.17 receiver training sequencer.
// Depends on nothing; included by modules that carry assertions.
`ifndef V17_RECEIVER_TRAINING_SEQUENCER_TOP_DEFINES_SVH
`define V17_RECEIVER_TRAINING_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define V17_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("v17 training sequencer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define V17_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("v17 training sequencer: next-cycle check failed");

`endif

>>> rtl/core/v17rts_pkg.sv
// Package for the V.17 receiver training sequencer: word types, phase
// and status codes, register indexes and sizing constants. No dependencies.
package v17rts_pkg;

    localparam int COUNT_WIDTH = 10;
    localparam int ADDR_WIDTH  = 4;

    // Mask applied to the per-block symbol count.
    localparam logic [9:0] COUNT_MASK = 10'((32'd1 << COUNT_WIDTH) - 32'd1);

    localparam logic [15:0] EPOCH_COUNT  = 16'd5;
    localparam logic [15:0] PROTO_COUNT  = 16'd62;
    localparam logic [15:0] SHORT_COUNT  = 16'd1;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_EPOCH    = 3'd1,
        PH_PROTOCOL = 3'd2,
        PH_BRIDGE   = 3'd3,
        PH_SCRAM    = 3'd4,
        PH_DATA     = 3'd5,
        PH_ERROR    = 3'd6
    } t_phase;

    localparam logic [2:0] ST_START     = 3'd0;
    localparam logic [2:0] ST_CARRIER   = 3'd1;
    localparam logic [2:0] ST_DATA      = 3'd2;
    localparam logic [2:0] ST_ERROR     = 3'd3;
    localparam logic [2:0] ST_RATE_BASE = 3'd4;

    typedef enum logic [1:0] {
        REG_QUICK_RETRAIN = 2'd0,
        REG_RATE_SELECT   = 2'd1,
        REG_SNR_THRESHOLD = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic       done;
        logic       low_snr;
        logic       error;
        logic       data;
        logic       carrier;
    } t_flags;

    typedef struct packed {
        logic               carrier_seen;
        logic               data_carrier_seen;
        logic               epoch_seen;
        logic signed [15:0] snr_estimate;
        logic               quality_unreliable;
        logic [9:0]         symbol_count;
        logic               stop_request;
    } t_in_word;

    typedef struct packed {
        logic       carrier_flag;
        logic       data_flag;
        logic       error_flag;
        logic       low_snr_flag;
        logic       done_flag;
        logic [2:0] status_code;
        logic [9:0] delivered_count;
        logic [2:0] phase;
        logic       agc_advance;
        logic       agc_freeze;
        logic       rate_restore;
        logic       coef_store;
    } t_out_word;

endpackage

>>> rtl/core/v17_receiver_training_sequencer_top.sv
// V.17 receiver training sequencer, top level; needs v17rts_pkg and the defines header.
// Latency: the result word is valid the cycle after its input word is taken.
// Throughput: one word per cycle; input ready is high while the result register
// is empty or draining, so a held result word holds the input side.
// Reset (synchronous, i_rst_n low): phase start, countdown zero, flags and
// status clear, quick_retrain 0, rate_select 3, snr_threshold 0, no result.
`include "v17_receiver_training_sequencer_top_defines.svh"

module v17_receiver_training_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input word channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  v17rts_pkg::t_in_word              i_in_word,
    // result word channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output v17rts_pkg::t_out_word             o_out_word,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [v17rts_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                r_quick_retrain;
    logic [1:0]          r_rate_select;
    logic signed [15:0]  r_snr_threshold;
    logic                cfg_write;
    v17rts_pkg::t_reg_idx cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = v17rts_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quick_retrain <= 1'b0;
            r_rate_select   <= 2'd3;
            r_snr_threshold <= 16'sd0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                v17rts_pkg::REG_QUICK_RETRAIN: r_quick_retrain <= pwdata[0];
                v17rts_pkg::REG_RATE_SELECT:   r_rate_select   <= pwdata[1:0];
                v17rts_pkg::REG_SNR_THRESHOLD: r_snr_threshold <= pwdata[15:0];
                default: ; // index three: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            v17rts_pkg::REG_QUICK_RETRAIN: prdata = {31'd0, r_quick_retrain};
            v17rts_pkg::REG_RATE_SELECT:   prdata = {30'd0, r_rate_select};
            v17rts_pkg::REG_SNR_THRESHOLD: prdata = {16'd0, r_snr_threshold};
            default:                       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    v17rts_pkg::t_phase   r_phase,  n_phase;
    logic [15:0]          r_count,  n_count;
    v17rts_pkg::t_flags   r_flags,  n_flags;
    logic [2:0]           r_status, n_status;

    logic                 r_out_valid;
    v17rts_pkg::t_out_word r_out_word, n_out_word;

    logic                 in_take;
    logic [15:0]          count_dec;
    logic                 expired;
    logic                 snr_low;
    logic [9:0]           symbols;
    logic [9:0]           delivered;
    logic                 adv, frz, rst_rate, cst;

    // Take a new word whenever the result register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    assign count_dec = r_count - 16'd1;
    // Expiry: the decremented countdown, read as signed, is zero or negative.
    assign expired   = (count_dec == 16'd0) || count_dec[15];
    assign snr_low   = i_in_word.snr_estimate <= r_snr_threshold;
    assign symbols   = i_in_word.symbol_count & v17rts_pkg::COUNT_MASK;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_flags   = r_flags;
        n_status  = r_status;
        delivered = 10'd0;
        adv       = 1'b0;
        frz       = 1'b0;
        rst_rate  = 1'b0;
        cst       = 1'b0;

        // The error flag only reports the current block.
        n_flags.error = 1'b0;

        unique case (r_phase) inside
            v17rts_pkg::PH_START: begin
                n_flags.carrier = 1'b0;
                n_status        = v17rts_pkg::ST_START;
                if (i_in_word.carrier_seen) begin
                    n_flags.carrier = 1'b1;
                    n_count         = v17rts_pkg::EPOCH_COUNT;
                    n_phase         = v17rts_pkg::PH_EPOCH;
                    n_flags.done    = 1'b0;
                    n_flags.data    = 1'b0;
                end
            end
            v17rts_pkg::PH_EPOCH: begin
                if (!i_in_word.carrier_seen) begin
                    n_phase         = v17rts_pkg::PH_ERROR;
                    n_status        = v17rts_pkg::ST_ERROR;
                    n_flags.error   = 1'b1;
                    n_flags.carrier = 1'b0;
                end else begin
                    n_flags.carrier = 1'b1;
                    n_status        = v17rts_pkg::ST_CARRIER;
                    n_count         = count_dec;
                    if (expired || i_in_word.epoch_seen) begin
                        rst_rate     = r_quick_retrain;
                        n_count      = r_quick_retrain ? v17rts_pkg::SHORT_COUNT
                                                       : v17rts_pkg::PROTO_COUNT;
                        n_phase      = v17rts_pkg::PH_PROTOCOL;
                        n_flags.done = 1'b0;
                        n_flags.data = 1'b0;
                        adv          = 1'b1;
                    end
                end
            end
            v17rts_pkg::PH_PROTOCOL, v17rts_pkg::PH_BRIDGE, v17rts_pkg::PH_SCRAM: begin
                if (!i_in_word.carrier_seen) begin
                    n_phase         = v17rts_pkg::PH_ERROR;
                    n_status        = v17rts_pkg::ST_ERROR;
                    n_flags.error   = 1'b1;
                    n_flags.carrier = 1'b0;
                end else begin
                    n_flags.carrier = 1'b1;
                    n_status        = v17rts_pkg::ST_CARRIER;
                    n_count         = count_dec;
                    if (expired) begin
                        if (snr_low) begin
                            n_flags.low_snr = 1'b1;
                        end
                        delivered = symbols;
                        if (r_phase == v17rts_pkg::PH_PROTOCOL) begin
                            n_count      = v17rts_pkg::SHORT_COUNT;
                            n_flags.data = 1'b0;
                            if (r_quick_retrain) begin
                                // Short retrain skips the bridge.
                                n_phase = v17rts_pkg::PH_SCRAM;
                            end else begin
                                n_phase      = v17rts_pkg::PH_BRIDGE;
                                cst          = 1'b1;
                                n_flags.done = 1'b0;
                            end
                        end else if (r_phase == v17rts_pkg::PH_BRIDGE) begin
                            n_count      = v17rts_pkg::SHORT_COUNT;
                            n_phase      = v17rts_pkg::PH_SCRAM;
                            n_flags.done = 1'b0;
                            n_flags.data = 1'b0;
                        end else begin
                            n_status     = v17rts_pkg::ST_RATE_BASE + {1'b0, r_rate_select};
                            frz          = 1'b1;
                            n_count      = 16'd0;
                            n_phase      = v17rts_pkg::PH_DATA;
                            n_flags.done = 1'b0;
                            n_flags.data = 1'b1;
                        end
                    end
                end
            end
            v17rts_pkg::PH_DATA: begin
                n_flags.carrier = 1'b1;
                n_status        = v17rts_pkg::ST_DATA;
                if (!i_in_word.data_carrier_seen || i_in_word.stop_request) begin
                    n_flags.carrier = 1'b0;
                end else begin
                    delivered       = i_in_word.quality_unreliable ? 10'd0 : symbols;
                    n_flags.low_snr = snr_low;
                end
            end
            default: begin
                // Error phase latches; the unused code behaves the same way.
                n_flags.error = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_word.carrier_flag    = n_flags.carrier;
        n_out_word.data_flag       = n_flags.data;
        n_out_word.error_flag      = n_flags.error;
        n_out_word.low_snr_flag    = n_flags.low_snr;
        n_out_word.done_flag       = n_flags.done;
        n_out_word.status_code     = n_status;
        n_out_word.delivered_count = delivered;
        n_out_word.phase           = n_phase;
        n_out_word.agc_advance     = adv;
        n_out_word.agc_freeze      = frz;
        n_out_word.rate_restore    = rst_rate;
        n_out_word.coef_store      = cst;
    end

    // Advance the sequencer state only on a taken word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= v17rts_pkg::PH_START;
            r_count  <= 16'd0;
            r_flags  <= '0;
            r_status <= v17rts_pkg::ST_START;
        end else if (in_take) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_flags  <= n_flags;
            r_status <= n_status;
        end
    end

    // Result register: load on a taken word, drop valid once drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `V17_ASSERT_NEXT(a_error_latches, i_clk, i_rst_n, r_phase == v17rts_pkg::PH_ERROR, r_phase == v17rts_pkg::PH_ERROR)
    `V17_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, in_take, o_out_valid)
    `V17_ASSERT_IMPLY(a_freeze_enters_data, i_clk, i_rst_n, o_out_valid && o_out_word.agc_freeze, o_out_word.phase == v17rts_pkg::PH_DATA)
    `V17_ASSERT_IMPLY(a_store_enters_bridge, i_clk, i_rst_n, o_out_valid && o_out_word.coef_store, o_out_word.phase == v17rts_pkg::PH_BRIDGE)
    `V17_ASSERT_IMPLY(a_error_flag_phase, i_clk, i_rst_n, o_out_valid && o_out_word.error_flag, o_out_word.phase == v17rts_pkg::PH_ERROR)

endmodule

>>> tb/sv/v17_receiver_training_sequencer_checker.sv
// Checker for the V.17 receiver training sequencer: watches the word channels and
// the APB write port, predicts each result word and compares it field by field.
// Depends on v17rts_pkg.
module v17_receiver_training_sequencer_checker
    import v17rts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_word,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [ADDR_WIDTH-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted sequencer state and register copies.
    t_phase             trn_phase;
    logic [15:0]        hold_count;
    t_flags             flags;
    logic [2:0]         status;
    logic               quick_retrain;
    logic [1:0]         rate_sel;
    logic signed [15:0] snr_thr;

    t_out_word expected_words[$];
    int        n_results;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        n_results    = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        o_fail_count++;
        if (o_fail_count <= 40) begin
            $display("word %0d: %s expected %0d got %0d", n_results, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            report_mismatch(what, want, got);
        end
    endtask

    function automatic logic counted_out();
        return (hold_count == 16'd0) || hold_count[15];
    endfunction

    // Carrier lost during training: latch the error phase.
    function automatic void fall_to_error();
        trn_phase     = PH_ERROR;
        status        = ST_ERROR;
        flags.error   = 1'b1;
        flags.carrier = 1'b0;
    endfunction

    // Advance the training phases by one sample block and form its result word.
    function automatic t_out_word step_training(input t_in_word w);
        t_out_word  r;
        logic       snr_low;
        logic [9:0] n;
        r       = '0;
        snr_low = $signed(w.snr_estimate) <= snr_thr;
        n       = w.symbol_count & COUNT_MASK;
        flags.error = 1'b0;
        case (trn_phase)
            PH_START: begin
                flags.carrier = 1'b0;
                status        = ST_START;
                if (w.carrier_seen) begin
                    flags.carrier = 1'b1;
                    flags.done    = 1'b0;
                    flags.data    = 1'b0;
                    hold_count    = EPOCH_COUNT;
                    trn_phase     = PH_EPOCH;
                end
            end
            PH_EPOCH: begin
                if (!w.carrier_seen) begin
                    fall_to_error();
                end else begin
                    flags.carrier = 1'b1;
                    status        = ST_CARRIER;
                    hold_count    = hold_count - 16'd1;
                    if (counted_out() || w.epoch_seen) begin
                        r.rate_restore = quick_retrain;
                        r.agc_advance  = 1'b1;
                        hold_count     = quick_retrain ? SHORT_COUNT : PROTO_COUNT;
                        trn_phase      = PH_PROTOCOL;
                        flags.done     = 1'b0;
                        flags.data     = 1'b0;
                    end
                end
            end
            PH_PROTOCOL, PH_BRIDGE, PH_SCRAM: begin
                if (!w.carrier_seen) begin
                    fall_to_error();
                end else begin
                    flags.carrier = 1'b1;
                    status        = ST_CARRIER;
                    hold_count    = hold_count - 16'd1;
                    if (counted_out()) begin
                        if (trn_phase == PH_SCRAM) begin
                            status = ST_RATE_BASE + {1'b0, rate_sel};
                        end
                        if (snr_low) begin
                            flags.low_snr = 1'b1;
                        end
                        case (trn_phase)
                            PH_PROTOCOL: begin
                                hold_count = SHORT_COUNT;
                                flags.data = 1'b0;
                                if (quick_retrain) begin
                                    trn_phase = PH_SCRAM;
                                end else begin
                                    trn_phase    = PH_BRIDGE;
                                    r.coef_store = 1'b1;
                                    flags.done   = 1'b0;
                                end
                            end
                            PH_BRIDGE: begin
                                hold_count = SHORT_COUNT;
                                trn_phase  = PH_SCRAM;
                                flags.done = 1'b0;
                                flags.data = 1'b0;
                            end
                            default: begin
                                r.agc_freeze = 1'b1;
                                hold_count   = 16'd0;
                                trn_phase    = PH_DATA;
                                flags.done   = 1'b0;
                                flags.data   = 1'b1;
                            end
                        endcase
                        r.delivered_count = n;
                    end
                end
            end
            PH_DATA: begin
                flags.carrier = 1'b1;
                status        = ST_DATA;
                if (!w.data_carrier_seen || w.stop_request) begin
                    flags.carrier = 1'b0;
                end else begin
                    r.delivered_count = w.quality_unreliable ? 10'd0 : n;
                    flags.low_snr     = snr_low;
                end
            end
            default: begin
                flags.error = 1'b1;
            end
        endcase
        r.carrier_flag = flags.carrier;
        r.data_flag    = flags.data;
        r.error_flag   = flags.error;
        r.low_snr_flag = flags.low_snr;
        r.done_flag    = flags.done;
        r.status_code  = status;
        r.phase        = trn_phase;
        return r;
    endfunction

    task automatic compare_word(input t_out_word want, input t_out_word got);
        check_field("carrier_flag", want.carrier_flag, got.carrier_flag);
        check_field("data_flag", want.data_flag, got.data_flag);
        check_field("error_flag", want.error_flag, got.error_flag);
        check_field("low_snr_flag", want.low_snr_flag, got.low_snr_flag);
        check_field("done_flag", want.done_flag, got.done_flag);
        check_field("status_code", want.status_code, got.status_code);
        check_field("delivered_count", want.delivered_count, got.delivered_count);
        check_field("phase", want.phase, got.phase);
        check_field("agc_advance", want.agc_advance, got.agc_advance);
        check_field("agc_freeze", want.agc_freeze, got.agc_freeze);
        check_field("rate_restore", want.rate_restore, got.rate_restore);
        check_field("coef_store", want.coef_store, got.coef_store);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            trn_phase     = PH_START;
            hold_count    = 16'd0;
            flags         = '0;
            status        = ST_START;
            quick_retrain = 1'b0;
            rate_sel      = 2'd3;
            snr_thr       = 16'sd0;
            expected_words.delete();
        end else begin
            // Result leaving now belongs to an earlier word: compare before predicting.
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", 0, 1);
                end else begin
                    want = expected_words.pop_front();
                    compare_word(want, i_out_word);
                end
                n_results++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(step_training(i_in_word));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_WIDTH-1:2])
                    REG_QUICK_RETRAIN: quick_retrain = i_pwdata[0];
                    REG_RATE_SELECT:   rate_sel      = i_pwdata[1:0];
                    REG_SNR_THRESHOLD: snr_thr       = i_pwdata[15:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> tb/sv/v17_receiver_training_sequencer_top_tb.sv
// Testbench top for the V.17 receiver training sequencer: clock, reset, stimulus
// and verdict. Depends on v17rts_pkg, the sequencer RTL and the checker module.
module v17_receiver_training_sequencer_top_tb;
    import v17rts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {TRAIN_LONG, TRAIN_SHORT, TRAIN_MIXED} t_train_mode;

    // Address slot past the last register; writes there must be dropped.
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_word   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr       = '0;
    logic [31:0]           pwdata      = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int pending;

    // Idle rates in percent per cycle, changed between stimulus phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic signed [15:0] cur_thr = 16'sd0;

    // Training walk controls: which carrier block (if any) goes missing.
    logic drop_carrier;
    int   drop_at;
    int   train_idx;

    v17_receiver_training_sequencer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    v17_receiver_training_sequencer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at the current rate; one decision per cycle.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case the sequencer hangs a handshake.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Pick an SNR: extremes, a value hugging the threshold, or anything at all.
    function automatic logic [15:0] pick_snr();
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(1) ? 32767 : -32768;
            1: v = int'(cur_thr) + int'($urandom_range(4)) - 2;
            default: v = int'($signed(16'($urandom)));
        endcase
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    function automatic t_in_word random_block();
        t_in_word w;
        w.carrier_seen       = 1'($urandom_range(1));
        w.data_carrier_seen  = ($urandom_range(99) < 85);
        w.epoch_seen         = 1'($urandom_range(1));
        w.snr_estimate       = pick_snr();
        w.quality_unreliable = ($urandom_range(3) == 0);
        w.symbol_count       = 10'($urandom_range(1023));
        w.stop_request       = ($urandom_range(9) == 0);
        return w;
    endfunction

    // Offer one word and hold it until taken; valid stays high on return.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Training block: carrier held except at the one chosen drop point.
    task automatic send_train(input t_in_word w);
        w.carrier_seen = !(drop_carrier && train_idx == drop_at);
        train_idx++;
        send_word(w);
    endtask

    // Drain, then write one register through a setup and an access cycle.
    // Junk above the register width checks that the upper bits are ignored.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value,
                             input int width);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= ($urandom << width) | 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idling(input int pattern);
        case (pattern)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    initial begin : stimulus
        t_train_mode   mode;
        t_in_word      w;
        int            k;
        int            p;
        int            waited;
        logic [15:0]   thr_setting;

        // Hold reset, then release it for good.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        mode         = t_train_mode'($urandom_range(2));
        drop_carrier = ($urandom_range(3) == 0);
        drop_at      = $urandom_range(12);
        train_idx    = 0;

        cur_thr = -16'sd32768;
        write_reg(REG_SNR_THRESHOLD, cur_thr, 16);
        write_reg(REG_RATE_SELECT, 16'd0, 2);
        write_reg(REG_QUICK_RETRAIN, (mode == TRAIN_LONG) ? 16'd0 : 16'd1, 1);
        set_idling($urandom_range(3));

        // Start phase: no carrier, every other field at its extremes.
        w = '0;
        send_word(w);
        w = '1;
        w.carrier_seen = 1'b0;
        send_word(w);
        w.snr_estimate = 16'sh8000;
        w.symbol_count = 10'd0;
        send_word(w);

        // Carrier arrives: enter epoch detect.
        w = random_block();
        send_train(w);

        // Epoch detect: leave on a seen epoch or when the countdown runs out.
        for (k = 1; k <= 5; k++) begin
            w = random_block();
            w.epoch_seen = (k < 5) ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
            send_train(w);
            if (w.epoch_seen) begin
                break;
            end
        end

        // Mixed walk: rate restored on the short path, then bridge on the long one.
        if (mode == TRAIN_MIXED) begin
            write_reg(REG_QUICK_RETRAIN, 16'd0, 1);
        end

        // Protocol, bridge where the walk has one, then scrambler sync.
        repeat ((mode == TRAIN_LONG) ? int'(PROTO_COUNT) : 1) send_train(random_block());
        if (mode != TRAIN_SHORT) begin
            send_train(random_block());
        end
        write_reg(REG_RATE_SELECT, 16'($urandom_range(3)), 2);
        send_train(random_block());

        // Data phase corners: lowest SNR, unreliable quality, stop, lost data carrier.
        w = '0;
        w.data_carrier_seen = 1'b1;
        w.symbol_count      = 10'h3FF;
        w.snr_estimate      = 16'sh8000;
        send_word(w);
        w.quality_unreliable = 1'b1;
        w.snr_estimate       = 16'sh7FFF;
        send_word(w);
        w.quality_unreliable = 1'b0;
        w.stop_request       = 1'b1;
        send_word(w);
        w.stop_request      = 1'b0;
        w.data_carrier_seen = 1'b0;
        w.carrier_seen      = 1'b1;
        send_word(w);

        // Random blocks over each idling pattern and threshold setting.
        for (p = 0; p < 4; p++) begin
            case (p)
                0: thr_setting = 16'h7FFF;
                1: thr_setting = 16'($urandom);
                2: thr_setting = 16'h0000;
                default: thr_setting = 16'h8000;
            endcase
            cur_thr = thr_setting;
            write_reg(REG_SNR_THRESHOLD, thr_setting, 16);
            write_reg(REG_QUICK_RETRAIN, 16'($urandom_range(1)), 1);
            write_reg(REG_RATE_SELECT, 16'($urandom_range(3)), 2);
            if (p == 1) begin
                write_reg(REG_SPARE, 16'($urandom), 16);
            end
            set_idling(p);
            repeat (370) send_word(random_block());
        end

        // Drop valid and wait for the last results, with a bound.
        i_in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < 2000);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
